// File: rtl/chi_pkg.sv
`timescale 1ns / 1ps
package chi_pkg;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OUTSIDE = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;
   localparam logic [1:0] ST_SAT     = 2'd3;

   typedef struct packed {
      logic signed [31:0] query_point;
      logic signed [31:0] left_end;
      logic signed [31:0] right_end;
      logic signed [31:0] left_value;
      logic signed [31:0] right_value;
      logic signed [31:0] left_slope;
      logic signed [31:0] right_slope;
   } chi_req_type;

   typedef struct packed {
      logic signed [31:0] interp_value;
      logic [1:0]         status;
   } chi_rsp_type;

   // operands that ride alongside the divider and the polynomial stages
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] y1;
      logic signed [31:0] y2;
      logic signed [31:0] d1;
      logic signed [31:0] d2;
      logic [32:0]        scale;
   } chi_side_type;

endpackage

// File: rtl/chi_div_stage.sv
`timescale 1ns / 1ps
module chi_div_stage #(
   parameter int FRAC_BITS = 16,
   parameter int BIT_POS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  chi_pkg::chi_side_type in_side,
   input  logic [33:0]          in_rem,
   input  logic [FRAC_BITS:0]   in_quot,
   output logic                 out_valid,
   output chi_pkg::chi_side_type out_side,
   output logic [33:0]          out_rem,
   output logic [FRAC_BITS:0]   out_quot
);
   import chi_pkg::*;

   logic [33:0]        trial;
   logic               fits;
   logic [33:0]        rem_in;
   logic [FRAC_BITS:0] quot_in;
   logic               valid_ff;
   chi_side_type       side_ff;
   logic [33:0]        rem_ff;
   logic [FRAC_BITS:0] quot_ff;

   generate
      if (BIT_POS == FRAC_BITS) begin : g_first
         assign trial = in_rem;
      end else begin : g_next
         assign trial = {in_rem[32:0], 1'b0};
      end
   endgenerate

   always_comb begin
      fits    = (trial >= {1'b0, in_side.scale});
      rem_in  = fits ? (trial - {1'b0, in_side.scale}) : trial;
      quot_in = in_quot;
      quot_in[BIT_POS] = fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_quot  = quot_ff;

endmodule

// File: rtl/chi_eval.sv
`timescale 1ns / 1ps
module chi_eval #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  chi_pkg::chi_side_type in_side,
   input  logic [FRAC_BITS:0]   in_u,
   output logic                 out_valid,
   output chi_pkg::chi_rsp_type out_rsp
);
   import chi_pkg::*;

   localparam int UW = FRAC_BITS + 1;
   localparam int HW = FRAC_BITS + 4;
   localparam int PW = 32 + HW;
   localparam int SV = PW - FRAC_BITS;
   localparam int MW = SV + 34;
   localparam int SW = MW + 2;
   localparam logic [HW-1:0] ONE = HW'(1) << FRAC_BITS;

   // stage a: square
   logic               va_ff;
   chi_side_type       sa_ff;
   logic [UW-1:0]      ua_ff, u2a_ff;
   logic [2*UW-1:0]    sq_in;
   // stage b: cube
   logic               vb_ff;
   chi_side_type       sb_ff;
   logic [UW-1:0]      ub_ff, u2b_ff, u3b_ff;
   logic [2*UW-1:0]    cu_in;
   // stage c: basis
   logic               vc_ff;
   chi_side_type       sc_ff;
   logic signed [HW-1:0] h1_ff, h2_ff, h3_ff, h4_ff;
   logic signed [HW-1:0] u_s, u2_s, u3_s;
   // stage d: weighted products
   logic               vd_ff;
   chi_side_type       sd_ff;
   logic signed [PW-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   // stage e: floor shift
   logic               ve_ff;
   chi_side_type       se_ff;
   logic signed [SV-1:0] t1_ff, t2_ff, s3_ff, s4_ff;
   // stage f: slope scaling
   logic               vf_ff;
   chi_side_type       sf_ff;
   logic signed [SV-1:0] t1f_ff, t2f_ff;
   logic signed [MW-1:0] m3_ff, m4_ff;
   // stage g: sum
   logic               vg_ff;
   chi_side_type       sg_ff;
   logic signed [SW-1:0] sum_ff;
   // stage h: saturate
   logic               vh_ff;
   chi_rsp_type        rsp_ff, rsp_in;
   logic               over_pos, over_neg;

   assign sq_in = in_u * in_u;
   assign cu_in = u2a_ff * ua_ff;
   assign u_s   = $signed(HW'(ub_ff));
   assign u2_s  = $signed(HW'(u2b_ff));
   assign u3_s  = $signed(HW'(u3b_ff));

   always_comb begin
      over_pos = !sum_ff[SW-1] && (sum_ff[SW-2:31] != '0);
      over_neg = sum_ff[SW-1] && (sum_ff[SW-2:31] != '1);
      rsp_in.status       = sg_ff.status;
      rsp_in.interp_value = sum_ff[31:0];
      if (sg_ff.status != ST_OK) begin
         rsp_in.interp_value = '0;
      end else if (over_pos) begin
         rsp_in.interp_value = 32'sh7fffffff;
         rsp_in.status       = ST_SAT;
      end else if (over_neg) begin
         rsp_in.interp_value = 32'sh80000000;
         rsp_in.status       = ST_SAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
         vh_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
         vh_ff <= vg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff  <= in_side;
         ua_ff  <= in_u;
         u2a_ff <= UW'(sq_in >> FRAC_BITS);

         sb_ff  <= sa_ff;
         ub_ff  <= ua_ff;
         u2b_ff <= u2a_ff;
         u3b_ff <= UW'(cu_in >> FRAC_BITS);

         sc_ff <= sb_ff;
         h1_ff <= HW'(2 * u3_s - 3 * u2_s + $signed(ONE));
         h2_ff <= HW'(3 * u2_s - 2 * u3_s);
         h3_ff <= HW'(u3_s - 2 * u2_s + u_s);
         h4_ff <= u3_s - u2_s;

         sd_ff <= sc_ff;
         p1_ff <= sc_ff.y1 * h1_ff;
         p2_ff <= sc_ff.y2 * h2_ff;
         p3_ff <= sc_ff.d1 * h3_ff;
         p4_ff <= sc_ff.d2 * h4_ff;

         se_ff <= sd_ff;
         t1_ff <= SV'(p1_ff >>> FRAC_BITS);
         t2_ff <= SV'(p2_ff >>> FRAC_BITS);
         s3_ff <= SV'(p3_ff >>> FRAC_BITS);
         s4_ff <= SV'(p4_ff >>> FRAC_BITS);

         sf_ff  <= se_ff;
         t1f_ff <= t1_ff;
         t2f_ff <= t2_ff;
         m3_ff  <= s3_ff * $signed({1'b0, se_ff.scale});
         m4_ff  <= s4_ff * $signed({1'b0, se_ff.scale});

         sg_ff  <= sf_ff;
         sum_ff <= SW'(t1f_ff) + SW'(t2f_ff) + SW'(m3_ff >>> FRAC_BITS)
                 + SW'(m4_ff >>> FRAC_BITS);

         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vh_ff;
   assign out_rsp   = rsp_ff;

endmodule

// File: rtl/cubic_hermite_interpolator.sv
`timescale 1ns / 1ps
// Cubic Hermite interpolator, signed fixed point with FRAC_BITS fraction bits.
// A new beat is taken every cycle unless the output beat waits. Each request
// passes through one input stage, FRAC_BITS + 1 restoring divider
// stages (one quotient bit each) that map the query point into the unit
// interval, then eight stages of squaring, cubing, basis forming, weighting,
// slope scaling, summing and saturation. The whole pipeline holds while the
// output beat waits. An empty interval returns zero with status 2, a point
// outside the interval zero with status 1, and an overflowing sum is clamped
// with status 3.
module cubic_hermite_interpolator #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  chi_pkg::chi_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output chi_pkg::chi_rsp_type rsp_data
);
   import chi_pkg::*;

   localparam int NDIV = FRAC_BITS + 1;

   logic         en;
   logic         v0_ff;
   chi_side_type s0_ff;
   logic [33:0]  rem0_ff;
   chi_side_type side_in;
   logic [32:0]  diff_in;

   logic               dv [NDIV+1];
   chi_side_type       ds [NDIV+1];
   logic [33:0]        dr [NDIV+1];
   logic [FRAC_BITS:0] dq [NDIV+1];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_comb begin
      diff_in        = {req_data.query_point[31], req_data.query_point}
                     - {req_data.left_end[31], req_data.left_end};
      side_in.y1     = req_data.left_value;
      side_in.y2     = req_data.right_value;
      side_in.d1     = req_data.left_slope;
      side_in.d2     = req_data.right_slope;
      side_in.scale  = {req_data.right_end[31], req_data.right_end}
                     - {req_data.left_end[31], req_data.left_end};
      side_in.status = ST_OK;
      if (req_data.right_end <= req_data.left_end) begin
         side_in.status = ST_EMPTY;
      end else if (req_data.query_point < req_data.left_end
                   || req_data.query_point > req_data.right_end) begin
         side_in.status = ST_OUTSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff   <= side_in;
         rem0_ff <= {1'b0, diff_in};
      end
   end

   assign dv[0] = v0_ff;
   assign ds[0] = s0_ff;
   assign dr[0] = rem0_ff;
   assign dq[0] = '0;

   generate
      for (genvar k = 0; k < NDIV; k++) begin : g_div
         chi_div_stage #(
            .FRAC_BITS(FRAC_BITS),
            .BIT_POS  (FRAC_BITS - k)
         ) u_stage (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .in_valid (dv[k]),
            .in_side  (ds[k]),
            .in_rem   (dr[k]),
            .in_quot  (dq[k]),
            .out_valid(dv[k+1]),
            .out_side (ds[k+1]),
            .out_rem  (dr[k+1]),
            .out_quot (dq[k+1])
         );
      end
   endgenerate

   chi_eval #(
      .FRAC_BITS(FRAC_BITS)
   ) u_eval (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (dv[NDIV]),
      .in_side  (ds[NDIV]),
      .in_u     (dq[NDIV]),
      .out_valid(rsp_valid),
      .out_rsp  (rsp_data)
   );

   default disable iff (reset);

   // normalised point never exceeds one
   a_u_range: assert property (@(posedge clock)
      dv[NDIV] && ds[NDIV].status == ST_OK
      |-> dq[NDIV] <= ((FRAC_BITS+1)'(1) << FRAC_BITS))
      else $error("normalised point above one");

   a_err_zero: assert property (@(posedge clock)
      rsp_valid && (rsp_data.status == ST_OUTSIDE || rsp_data.status == ST_EMPTY)
      |-> rsp_data.interp_value == '0)
      else $error("error beat with nonzero value");

   a_sat_clamp: assert property (@(posedge clock)
      rsp_valid && rsp_data.status == ST_SAT
      |-> rsp_data.interp_value == 32'sh7fffffff
          || rsp_data.interp_value == 32'sh80000000)
      else $error("saturated beat not clamped");

   a_hold_only_on_stall: assert property (@(posedge clock)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("pipeline held without output stall");

endmodule

// File: verif/cubic_hermite_checker.sv
`timescale 1ns / 1ps
module cubic_hermite_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  chi_pkg::chi_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  chi_pkg::chi_rsp_type rsp_data,
   output int                   fail_count,
   output int                   pending
);
   import chi_pkg::*;

   localparam int FB = 16;

   chi_rsp_type interp_queue[$];

   function automatic longint floor_div_one(longint x);
      return x >>> FB;
   endfunction

   function automatic chi_rsp_type hermite_eval(chi_req_type r);
      chi_rsp_type o;
      longint t, x1, x2, y1, y2, d1, d2, one, scale, u, u2, u3;
      longint h1, h2, h3, h4, sum;
      t = r.query_point; x1 = r.left_end; x2 = r.right_end;
      y1 = r.left_value; y2 = r.right_value; d1 = r.left_slope; d2 = r.right_slope;
      one = longint'(1) << FB;
      o.interp_value = '0;
      o.status = ST_OK;
      if (x2 <= x1) begin
         o.status = ST_EMPTY;
         return o;
      end
      if (t < x1 || t > x2) begin
         o.status = ST_OUTSIDE;
         return o;
      end
      scale = x2 - x1;
      u = ((t - x1) <<< FB) / scale;
      u2 = (u * u) >>> FB;
      u3 = (u2 * u) >>> FB;
      h1 = 2 * u3 - 3 * u2 + one;
      h2 = -2 * u3 + 3 * u2;
      h3 = u3 - 2 * u2 + u;
      h4 = u3 - u2;
      sum = floor_div_one(y1 * h1) + floor_div_one(floor_div_one(d1 * h3) * scale)
          + floor_div_one(y2 * h2) + floor_div_one(floor_div_one(d2 * h4) * scale);
      if (sum > 64'sd2147483647) begin
         sum = 64'sd2147483647;
         o.status = ST_SAT;
      end else if (sum < -64'sd2147483648) begin
         sum = -64'sd2147483648;
         o.status = ST_SAT;
      end
      o.interp_value = sum[31:0];
      return o;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;
   assign pending = interp_queue.size();

   always @(posedge clock) begin
      chi_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) interp_queue.push_back(hermite_eval(req_data));
         if (rsp_valid && rsp_ready) begin
            if (interp_queue.size() == 0) begin
               $display("unexpected beat: value %0d", rsp_data.interp_value);
               fail_count++;
            end else begin
               want = interp_queue.pop_front();
               if (rsp_data.interp_value !== want.interp_value)
                  report("interp_value", rsp_data.interp_value, want.interp_value);
               if (rsp_data.status !== want.status)
                  report("status", rsp_data.status, want.status);
            end
         end
      end
   end
endmodule

// File: verif/cubic_hermite_interpolator_tb.sv
`timescale 1ns / 1ps
module cubic_hermite_interpolator_tb;
   import chi_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   chi_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   chi_rsp_type rsp_data;
   int          fail_count, pending;
   int          cycle_count = 0;
   bit          sending_done = 0;
   bit          long_hold = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   cubic_hermite_interpolator DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   cubic_hermite_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .fail_count, .pending
   );

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return $urandom_range(0, 8) << 16;
         3: return -($urandom_range(0, 8) << 16);
         default: return $urandom();
      endcase
   endfunction

   function automatic chi_req_type make_item(int kind);
      chi_req_type r;
      longint lo, hi;
      r.left_value = rand_word();
      r.right_value = rand_word();
      r.left_slope = rand_word();
      r.right_slope = rand_word();
      r.left_end = rand_word();
      r.right_end = rand_word();
      r.query_point = rand_word();
      if (kind < 8) begin
         // well-formed interval with the point inside
         lo = $signed(rand_word());
         if ($urandom_range(0, 1)) hi = lo + $urandom_range(1, 1 << 20);
         else hi = lo + $urandom();
         if (hi > 64'sd2147483647) begin
            hi = 64'sd2147483647;
            if (lo >= hi) lo = hi - 1;
         end
         r.left_end = 32'(lo);
         r.right_end = 32'(hi);
         case ($urandom_range(0, 5))
            0: r.query_point = 32'(lo);
            1: r.query_point = 32'(hi);
            default: r.query_point = 32'(lo + ((hi - lo) * $urandom_range(0, 65535)) / 65535);
         endcase
         if ($urandom_range(0, 3) == 0) begin
            r.left_value = $signed(r.left_value) >>> 8;
            r.right_value = $signed(r.right_value) >>> 8;
         end
      end
      return r;
   endfunction

   task automatic send(chi_req_type r);
      int idle;
      idle = $urandom_range(0, 9);
      if (idle != 0) begin
         req_valid <= 0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_directed(logic [31:0] q, logic [31:0] a, logic [31:0] b,
                                logic [31:0] v1, logic [31:0] v2,
                                logic [31:0] s1, logic [31:0] s2);
      chi_req_type r;
      r = '{q, a, b, v1, v2, s1, s2};
      send(r);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // ordinary unit interval, ends and midpoint
      send_directed(32'h0000_0000, 32'h0, 32'h1_0000, 32'h1_0000, 32'h2_0000, 32'h1_0000, 32'hFFFF_0000);
      send_directed(32'h0001_0000, 32'h0, 32'h1_0000, 32'h1_0000, 32'h2_0000, 32'h1_0000, 32'hFFFF_0000);
      send_directed(32'h0000_8000, 32'h0, 32'h1_0000, 32'h1_0000, 32'h2_0000, 32'h1_0000, 32'hFFFF_0000);
      // empty interval, equal and reversed, and beats it overrides the range check
      send_directed(32'h5, 32'h5, 32'h5, 32'h1, 32'h1, 32'h1, 32'h1);
      send_directed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1, 32'h1, 32'h1);
      // point outside, below and above
      send_directed(32'h8000_0000, 32'h0, 32'h1_0000, 32'h1, 32'h1, 32'h1, 32'h1);
      send_directed(32'h7FFF_FFFF, 32'h0, 32'h1_0000, 32'h1, 32'h1, 32'h1, 32'h1);
      // widest interval with extreme values and slopes
      send_directed(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_directed(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_directed(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_directed(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      // smallest interval
      send_directed(32'h1, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000);
      // saturating sum
      send_directed(32'h4000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      for (int i = 0; i < 750; i++) begin
         if (i == 300) long_hold = 1;
         send(make_item($urandom_range(0, 9)));
      end
      req_valid <= 0;
      sending_done = 1;
   end

   // receiver: random stalls, one long hold-off while the sender keeps offering
   initial begin
      int idle;
      rsp_ready <= 0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            long_hold = 0;
            rsp_ready <= 0;
            repeat (200) @(posedge clock);
         end
         if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            idle = $urandom_range(0, 9);
            if (idle != 0) begin
               rsp_ready <= 0;
               repeat (idle) @(posedge clock);
            end
            rsp_ready <= 1;
            do @(posedge clock); while (!rsp_valid);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      wait (sending_done);
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/chi_pkg.sv
rtl/chi_div_stage.sv
rtl/chi_eval.sv
rtl/cubic_hermite_interpolator.sv
verif/cubic_hermite_checker.sv
verif/cubic_hermite_interpolator_tb.sv
